// ===== hw/rtl/jpeg_length_finder_macros.svh =====
// assertion macros used by the checker file
`ifndef JPEG_LENGTH_FINDER_MACROS_SVH
`define JPEG_LENGTH_FINDER_MACROS_SVH

// same-cycle implication, held off during reset
`define JLF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, held off during reset
`define JLF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/jlf_pkg.sv =====
`default_nettype none

package jlf_pkg;

   // width of the internal byte counter
   localparam int LENGTH_BITS = 26;
   // width of the reported length and of max_bytes
   localparam int JLF_LEN_W = 26;
   localparam int JLF_CMP_W = (LENGTH_BITS > JLF_LEN_W) ? LENGTH_BITS : JLF_LEN_W;

   // queue between front and back
   localparam int JLF_QUEUE_DEPTH = 4;
   localparam int JLF_PTR_W = $clog2(JLF_QUEUE_DEPTH);
   localparam int JLF_CNT_W = $clog2(JLF_QUEUE_DEPTH + 1);

   // marker bytes
   localparam logic [7:0] MARK_FF  = 8'hFF;
   localparam logic [7:0] MARK_SOI = 8'hD8;
   localparam logic [7:0] MARK_EOI = 8'hD9;
   localparam logic [7:0] MARK_SOS = 8'hDA;
   localparam logic [7:0] MARK_TEM = 8'h01;

   // parse status codes
   localparam logic [1:0] STATUS_COMPLETE  = 2'd0;
   localparam logic [1:0] STATUS_NOT_JPEG  = 2'd1;
   localparam logic [1:0] STATUS_BAD_MARK  = 2'd2;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd3;

   // register map: index taken from paddr[2]
   localparam logic CSR_IDX_MAX_BYTES = 1'b0;
   localparam logic [JLF_LEN_W-1:0] MAX_BYTES_RESET = JLF_LEN_W'(20 * 1024 * 1024);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
   } jlf_req_type;

   typedef struct packed {
      logic [JLF_LEN_W-1:0] jpeg_length;
      logic [1:0]           parse_status;
   } jlf_rsp_type;

   // byte classification done by the front
   typedef struct packed {
      logic is_ff;
      logic is_soi;
      logic is_eoi;
      logic is_sos;
      logic standalone;
      logic has_length;
      logic below_two;
      logic equals_two;
   } jlf_class_type;

   typedef struct packed {
      jlf_req_type   item;
      jlf_class_type cls;
   } jlf_entry_type;

   function automatic jlf_class_type classify(input logic [7:0] b);
      jlf_class_type c;
      c.is_ff      = (b == MARK_FF);
      c.is_soi     = (b == MARK_SOI);
      c.is_eoi     = (b == MARK_EOI);
      c.is_sos     = (b == MARK_SOS);
      c.standalone = (b == MARK_TEM) || (b >= 8'hD0 && b <= 8'hD9);
      c.has_length = (b >= 8'hC0 && b <= 8'hC9) || (b == 8'hCC) ||
                     (b >= 8'hDA && b <= 8'hDD) || (b >= 8'hE0 && b <= 8'hEF) ||
                     (b == 8'hFE);
      c.below_two  = (b < 8'd2);
      c.equals_two = (b == 8'd2);
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/jlf_csr.sv =====
`default_nettype none

module jlf_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [2:0]                    paddr,
   input  wire logic [31:0]                   pwdata,
   output logic      [31:0]                   prdata,
   output logic                               pready,
   output logic      [jlf_pkg::JLF_LEN_W-1:0] max_bytes
);

   logic [jlf_pkg::JLF_LEN_W-1:0] max_bytes_ff;
   logic [jlf_pkg::JLF_LEN_W-1:0] max_bytes_in;
   logic                          write_hit;

   // write decode on the access cycle
   assign write_hit = psel && penable && pwrite && (paddr[2] == jlf_pkg::CSR_IDX_MAX_BYTES);

   always_comb begin
      max_bytes_in = max_bytes_ff;
      if (write_hit) begin
         max_bytes_in = pwdata[jlf_pkg::JLF_LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_bytes_ff <= jlf_pkg::MAX_BYTES_RESET;
      end else begin
         max_bytes_ff <= max_bytes_in;
      end
   end

   // read back
   always_comb begin
      prdata = 32'd0;
      if (paddr[2] == jlf_pkg::CSR_IDX_MAX_BYTES) begin
         prdata = 32'(max_bytes_ff);
      end
   end

   assign pready    = 1'b1;
   assign max_bytes = max_bytes_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/jlf_front.sv =====
`default_nettype none

module jlf_front (
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire jlf_pkg::jlf_req_type   req_data,
   input  wire logic                   queue_full,
   output logic                        push,
   output jlf_pkg::jlf_entry_type      push_entry
);

   // take an item whenever the queue has room
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // classify the byte on the way in
   always_comb begin
      push_entry.item = req_data;
      push_entry.cls  = jlf_pkg::classify(req_data.data_byte);
   end

endmodule

`default_nettype wire

// ===== hw/rtl/jlf_queue.sv =====
`default_nettype none

module jlf_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire jlf_pkg::jlf_entry_type push_entry,
   output logic                        full,
   input  wire logic                   pop,
   output logic                        pop_valid,
   output jlf_pkg::jlf_entry_type      pop_entry
);

   jlf_pkg::jlf_entry_type             slot_ff [jlf_pkg::JLF_QUEUE_DEPTH];
   logic [jlf_pkg::JLF_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [jlf_pkg::JLF_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [jlf_pkg::JLF_CNT_W-1:0]      count_ff, count_in;
   logic                               do_pop;

   assign full      = (count_ff == jlf_pkg::JLF_CNT_W'(jlf_pkg::JLF_QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = slot_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + jlf_pkg::JLF_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + jlf_pkg::JLF_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + jlf_pkg::JLF_CNT_W'(1);
      end else if (do_pop && !push) begin
         count_in = count_ff - jlf_pkg::JLF_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/jlf_parser.sv =====
`default_nettype none

module jlf_parser (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [jlf_pkg::JLF_LEN_W-1:0] max_bytes,
   input  wire logic                          entry_valid,
   input  wire jlf_pkg::jlf_entry_type        entry,
   output logic                               entry_pop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output jlf_pkg::jlf_rsp_type               rsp_data
);

   typedef enum logic [3:0] {
      PH_IDLE, PH_SOI0, PH_SOI1, PH_MARK0, PH_MARK1, PH_LENH, PH_LENL, PH_SKIP, PH_SCAN
   } phase_type;

   localparam int LB = jlf_pkg::LENGTH_BITS;
   localparam logic [LB-1:0] POS_MAX = '1;

   phase_type              phase_ff, phase_in;
   logic [LB-1:0]          pos_ff, pos_in;
   logic [15:0]            skip_ff, skip_in;
   logic [7:0]             len_high_ff, len_high_in;
   logic                   sos_ff, sos_in;
   logic                   saw_ff_ff, saw_ff_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   jlf_pkg::jlf_rsp_type   rsp_data_ff, rsp_data_in;

   phase_type              cur_phase;
   logic [LB-1:0]          cur_pos;
   logic [LB-1:0]          prior_pos;
   logic                   active;
   logic                   hit;
   logic [1:0]             status;
   logic [LB-1:0]          len;
   logic                   commit;

   // back side moves when the result register is free or being taken
   assign entry_pop = entry_valid && (!rsp_valid_ff || !rsp_stall);
   assign active    = entry.item.first_byte || (phase_ff != PH_IDLE);
   assign commit    = entry_pop && active;

   // restart on first byte
   always_comb begin
      cur_phase = entry.item.first_byte ? PH_SOI0 : phase_ff;
      cur_pos   = entry.item.first_byte ? '0 : pos_ff;
      prior_pos = cur_pos;
   end

   // per-byte marker walk
   always_comb begin
      phase_in    = cur_phase;
      pos_in      = (cur_pos != POS_MAX) ? cur_pos + LB'(1) : cur_pos;
      skip_in     = entry.item.first_byte ? 16'd0 : skip_ff;
      len_high_in = entry.item.first_byte ? 8'd0  : len_high_ff;
      sos_in      = entry.item.first_byte ? 1'b0  : sos_ff;
      saw_ff_in   = entry.item.first_byte ? 1'b0  : saw_ff_ff;
      hit         = 1'b0;
      status      = jlf_pkg::STATUS_COMPLETE;
      len         = '0;

      unique case (cur_phase)
         PH_SOI0: begin
            if (entry.cls.is_ff) begin
               phase_in = PH_SOI1;
            end else begin
               hit    = 1'b1;
               status = jlf_pkg::STATUS_NOT_JPEG;
            end
         end
         PH_SOI1: begin
            if (entry.cls.is_soi) begin
               sos_in   = 1'b0;
               phase_in = PH_MARK0;
            end else begin
               hit    = 1'b1;
               status = jlf_pkg::STATUS_NOT_JPEG;
            end
         end
         PH_MARK0: begin
            if (entry.cls.is_ff) begin
               phase_in = PH_MARK1;
            end else begin
               hit    = 1'b1;
               status = jlf_pkg::STATUS_BAD_MARK;
               len    = prior_pos;
            end
         end
         PH_MARK1: begin
            if (entry.cls.standalone) begin
               sos_in = 1'b0;
               if (entry.cls.is_eoi) begin
                  hit    = 1'b1;
                  status = jlf_pkg::STATUS_COMPLETE;
                  len    = pos_in;
               end else begin
                  phase_in = PH_MARK0;
               end
            end else if (entry.cls.has_length) begin
               sos_in   = entry.cls.is_sos;
               phase_in = PH_LENH;
            end else begin
               hit    = 1'b1;
               status = jlf_pkg::STATUS_BAD_MARK;
               len    = prior_pos - LB'(1);
            end
         end
         PH_LENH: begin
            len_high_in = entry.item.data_byte;
            phase_in    = PH_LENL;
         end
         PH_LENL: begin
            if ((len_high_ff == 8'd0) && entry.cls.below_two) begin
               hit    = 1'b1;
               status = jlf_pkg::STATUS_BAD_MARK;
               len    = prior_pos - LB'(3);
            end else begin
               skip_in = {len_high_ff, entry.item.data_byte} - 16'd2;
               if ((len_high_ff == 8'd0) && entry.cls.equals_two) begin
                  saw_ff_in = 1'b0;
                  phase_in  = sos_ff ? PH_SCAN : PH_MARK0;
               end else begin
                  phase_in = PH_SKIP;
               end
            end
         end
         PH_SKIP: begin
            skip_in = skip_ff - 16'd1;
            if (skip_ff == 16'd1) begin
               saw_ff_in = 1'b0;
               phase_in  = sos_ff ? PH_SCAN : PH_MARK0;
            end
         end
         PH_SCAN: begin
            if (saw_ff_ff && entry.cls.is_eoi) begin
               hit    = 1'b1;
               status = jlf_pkg::STATUS_COMPLETE;
               len    = pos_in;
            end else begin
               saw_ff_in = entry.cls.is_ff;
            end
         end
         default: begin
         end
      endcase

      // end of data or byte limit, when the byte gave nothing else
      if (!hit && (entry.item.last_byte ||
                   (jlf_pkg::JLF_CMP_W'(pos_in) >= jlf_pkg::JLF_CMP_W'(max_bytes)))) begin
         hit = 1'b1;
         if ((phase_in == PH_SOI0) || (phase_in == PH_SOI1)) begin
            status = jlf_pkg::STATUS_NOT_JPEG;
            len    = '0;
         end else begin
            status = jlf_pkg::STATUS_TRUNCATED;
            len    = pos_in;
         end
      end

      if (hit) begin
         phase_in = PH_IDLE;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (entry_pop) begin
         rsp_valid_in = active && hit;
         rsp_data_in.jpeg_length  = jlf_pkg::JLF_LEN_W'(len);
         rsp_data_in.parse_status = status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            phase_ff <= phase_in;
         end
      end
      if (commit) begin
         pos_ff      <= pos_in;
         skip_ff     <= skip_in;
         len_high_ff <= len_high_in;
         sos_ff      <= sos_in;
         saw_ff_ff   <= saw_ff_in;
      end
      if (entry_pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/jpeg_length_finder.sv =====
// an accepted byte is written into the queue, and its result is registered in the parser's result register
// throughput: one byte per cycle while the result is not stalled, set by the per-byte marker walk in the parser
// a stalled result holds the parser; the four-entry queue keeps taking bytes meanwhile until it is full
// reset: synchronous, active high; clears queue, result and parser phase, max_bytes
// returns to 20971520; bytes are ignored until one with first_byte set arrives
`default_nettype none

module jpeg_length_finder (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire jlf_pkg::jlf_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output jlf_pkg::jlf_rsp_type      rsp_data,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [2:0]           paddr,
   input  wire logic [31:0]          pwdata,
   output logic      [31:0]          prdata,
   output logic                      pready
);

   logic [jlf_pkg::JLF_LEN_W-1:0] max_bytes;
   logic                          queue_full;
   logic                          push;
   jlf_pkg::jlf_entry_type        push_entry;
   logic                          entry_pop;
   logic                          entry_valid;
   jlf_pkg::jlf_entry_type        entry;

   // configuration register
   jlf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .max_bytes (max_bytes)
   );

   // accept and classify
   jlf_front u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // decoupling queue
   jlf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (entry_pop),
      .pop_valid  (entry_valid),
      .pop_entry  (entry)
   );

   // marker walk and result
   jlf_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .max_bytes   (max_bytes),
      .entry_valid (entry_valid),
      .entry       (entry),
      .entry_pop   (entry_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/jlf_checker.sv =====
`default_nettype none
`include "jpeg_length_finder_macros.svh"

module jlf_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_stall,
   input wire jlf_pkg::jlf_rsp_type rsp_data,
   input wire logic                 psel,
   input wire logic                 penable,
   input wire logic                 pwrite,
   input wire logic [2:0]           paddr,
   input wire logic [31:0]          pwdata,
   input wire logic [31:0]          prdata
);

   // a stalled result holds
   `JLF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result changed")

   // not-jpeg results carry zero length
   `JLF_ASSERT_NOW(a_not_jpeg_zero, clock, reset, rsp_valid && (rsp_data.parse_status == jlf_pkg::STATUS_NOT_JPEG), rsp_data.jpeg_length == '0, "not-jpeg length nonzero")

   // a complete image holds at least soi and eoi
   `JLF_ASSERT_NOW(a_complete_min, clock, reset, rsp_valid && (rsp_data.parse_status == jlf_pkg::STATUS_COMPLETE), rsp_data.jpeg_length >= 4, "complete length below four")

   // max_bytes reads back what was written
   `JLF_ASSERT_NEXT(a_csr_readback, clock, reset, psel && penable && pwrite && (paddr[2] == jlf_pkg::CSR_IDX_MAX_BYTES), (paddr[2] != jlf_pkg::CSR_IDX_MAX_BYTES) || (prdata[jlf_pkg::JLF_LEN_W-1:0] == $past(pwdata[jlf_pkg::JLF_LEN_W-1:0])), "max_bytes readback mismatch")

endmodule

bind jpeg_length_finder jlf_checker u_jlf_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .psel      (psel),
   .penable   (penable),
   .pwrite    (pwrite),
   .paddr     (paddr),
   .pwdata    (pwdata),
   .prdata    (prdata)
);

`default_nettype wire

// ===== verif/testbench.sv =====
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import jlf_pkg::*;

   typedef enum logic [3:0] {
      WALK_IDLE, WALK_SOI0, WALK_SOI1, WALK_MARK0, WALK_MARK1,
      WALK_LENH, WALK_LENL, WALK_SKIP, WALK_SCAN
   } walk_phase_e;

   logic              clock;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   jlf_req_type       req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   jlf_rsp_type       rsp_data;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [2:0]        paddr = '0;
   logic [31:0]       pwdata = '0;
   logic [31:0]       prdata;
   logic              pready;

   // stimulus and expected results
   jlf_req_type       pending_bytes[$];
   jlf_rsp_type       expected_lengths[$];
   int                idle_pct = 0;
   int                stall_pct = 0;
   int                hold_cycles = 0;
   int                queued_count = 0;
   int                error_count = 0;

   // predictor state
   walk_phase_e          walk_phase = WALK_IDLE;
   logic [LENGTH_BITS-1:0] walk_pos = '0;
   logic [16:0]          walk_skip = '0;
   logic [7:0]           walk_marker = '0;
   logic [7:0]           walk_len_hi = '0;
   logic                 walk_saw_ff = 1'b0;
   logic                 walk_done = 1'b1;
   logic [JLF_LEN_W-1:0] max_limit = MAX_BYTES_RESET;

   jpeg_length_finder u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   task automatic flag_error(input string what);
      error_count++;
      if (error_count <= 10) begin
         $display("mismatch: %s", what);
      end
   endtask

   function automatic bit is_standalone(input logic [7:0] b);
      return b == MARK_TEM || (b >= 8'hD0 && b <= 8'hD9);
   endfunction

   function automatic bit has_length(input logic [7:0] b);
      return (b >= 8'hC0 && b <= 8'hC9) || b == 8'hCC || (b >= 8'hDA && b <= 8'hDD) ||
             (b >= 8'hE0 && b <= 8'hEF) || b == 8'hFE;
   endfunction

   // segment done: entropy scan after sos, else next marker
   task automatic close_segment();
      walk_saw_ff = 1'b0;
      walk_phase = (walk_marker == MARK_SOS) ? WALK_SCAN : WALK_MARK0;
   endtask

   // advance the marker walk by one byte, queue the length report it gives
   task automatic walk_byte(input jlf_req_type it);
      logic [LENGTH_BITS-1:0] prior;
      logic [LENGTH_BITS-1:0] found_len;
      logic [1:0]             found_status;
      logic [16:0]            seg;
      logic                   hit;
      jlf_rsp_type            rsp;
      if (it.first_byte) begin
         walk_phase = WALK_SOI0;
         walk_pos = '0;
         walk_skip = '0;
         walk_marker = '0;
         walk_len_hi = '0;
         walk_saw_ff = 1'b0;
         walk_done = 1'b0;
      end else if (walk_done) begin
         return;
      end
      prior = walk_pos;
      if (walk_pos != '1) walk_pos = walk_pos + 1'b1;
      hit = 1'b0;
      found_len = '0;
      found_status = STATUS_COMPLETE;
      case (walk_phase)
         WALK_SOI0: begin
            if (it.data_byte == MARK_FF) walk_phase = WALK_SOI1;
            else begin hit = 1'b1; found_status = STATUS_NOT_JPEG; end
         end
         WALK_SOI1: begin
            if (it.data_byte == MARK_SOI) begin
               walk_marker = MARK_SOI;
               walk_phase = WALK_MARK0;
            end else begin
               hit = 1'b1;
               found_status = STATUS_NOT_JPEG;
            end
         end
         WALK_MARK0: begin
            if (it.data_byte == MARK_FF) walk_phase = WALK_MARK1;
            else begin hit = 1'b1; found_status = STATUS_BAD_MARK; found_len = prior; end
         end
         WALK_MARK1: begin
            if (is_standalone(it.data_byte)) begin
               walk_marker = it.data_byte;
               if (it.data_byte == MARK_EOI) begin
                  hit = 1'b1;
                  found_len = walk_pos;
               end else begin
                  walk_phase = WALK_MARK0;
               end
            end else if (has_length(it.data_byte)) begin
               walk_marker = it.data_byte;
               walk_phase = WALK_LENH;
            end else begin
               // unknown code, ff fill included: stop before the marker's ff
               hit = 1'b1;
               found_status = STATUS_BAD_MARK;
               found_len = prior - 1'b1;
            end
         end
         WALK_LENH: begin
            walk_len_hi = it.data_byte;
            walk_phase = WALK_LENL;
         end
         WALK_LENL: begin
            seg = {1'b0, walk_len_hi, it.data_byte};
            if (seg < 17'd2) begin
               hit = 1'b1;
               found_status = STATUS_BAD_MARK;
               found_len = prior - 2'd3;
            end else begin
               walk_skip = seg - 17'd2;
               if (walk_skip == '0) close_segment();
               else walk_phase = WALK_SKIP;
            end
         end
         WALK_SKIP: begin
            if (walk_skip != '0) walk_skip = walk_skip - 1'b1;
            if (walk_skip == '0) close_segment();
         end
         WALK_SCAN: begin
            if (walk_saw_ff && it.data_byte == MARK_EOI) begin
               hit = 1'b1;
               found_len = walk_pos;
            end else begin
               walk_saw_ff = (it.data_byte == MARK_FF);
            end
         end
         default: begin
            hit = 1'b1;
            found_status = STATUS_BAD_MARK;
            found_len = prior;
         end
      endcase
      // end of data or byte limit, only when the byte itself gave nothing
      if (!hit && (it.last_byte || walk_pos >= max_limit)) begin
         hit = 1'b1;
         if (walk_phase == WALK_SOI0 || walk_phase == WALK_SOI1) begin
            found_status = STATUS_NOT_JPEG;
            found_len = '0;
         end else begin
            found_status = STATUS_TRUNCATED;
            found_len = walk_pos;
         end
      end
      if (hit) begin
         rsp.jpeg_length = JLF_LEN_W'(found_len);
         rsp.parse_status = found_status;
         expected_lengths.push_back(rsp);
         walk_done = 1'b1;
         walk_phase = WALK_IDLE;
      end
   endtask

   // driver: present queued bytes, hold while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) walk_byte(req_data);
         if (!req_valid || !req_stall) begin
            if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
               req_valid <= 1'b1;
               req_data <= pending_bytes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall, with a counted long hold-off when requested
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // monitor: compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      jlf_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_lengths.size() == 0) begin
            flag_error($sformatf("unexpected result length %0d status %0d",
                                 rsp_data.jpeg_length, rsp_data.parse_status));
         end else begin
            want = expected_lengths.pop_front();
            if (rsp_data.jpeg_length !== want.jpeg_length ||
                rsp_data.parse_status !== want.parse_status) begin
               flag_error($sformatf("length exp %0d got %0d, status exp %0d got %0d",
                                    want.jpeg_length, rsp_data.jpeg_length,
                                    want.parse_status, rsp_data.parse_status));
            end
         end
      end
   end

   task automatic push_byte(input logic [7:0] v, input logic f, input logic l);
      jlf_req_type it;
      it.data_byte = v;
      it.first_byte = f;
      it.last_byte = l;
      pending_bytes.push_back(it);
   endtask

   // wait until every byte is taken and every result has come, then let the pipe empty
   task automatic drain();
      while (pending_bytes.size() != 0 || req_valid || expected_lengths.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_max_bytes(input logic [31:0] value);
      drain();
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {CSR_IDX_MAX_BYTES, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      max_limit = value[JLF_LEN_W-1:0];
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   function automatic logic [7:0] pick_standalone();
      int r;
      r = $urandom_range(0, 9);
      return (r == 0) ? MARK_TEM : 8'(8'hD0 + r - 1);
   endfunction

   function automatic logic [7:0] pick_length_code();
      int r;
      r = $urandom_range(0, 31);
      if (r < 10) return 8'(8'hC0 + r);
      if (r == 10) return 8'hCC;
      if (r < 15) return 8'(MARK_SOS + r - 11);
      if (r < 31) return 8'(8'hE0 + r - 15);
      return 8'hFE;
   endfunction

   // one candidate image: mostly well formed, sometimes corrupted, cut or junk
   task automatic add_candidate();
      logic [7:0]  img[$];
      logic [15:0] seglen;
      int          cut;
      logic        end_flag;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 6)) img.push_back(8'($urandom_range(0, 255)));
      end else begin
         img.push_back(MARK_FF);
         img.push_back(MARK_SOI);
         repeat ($urandom_range(0, 3)) begin
            img.push_back(MARK_FF);
            if ($urandom_range(0, 2) == 0) begin
               img.push_back(pick_standalone());
            end else begin
               img.push_back(pick_length_code());
               seglen = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(0, 65535))
                                                     : 16'($urandom_range(2, 10));
               img.push_back(seglen[15:8]);
               img.push_back(seglen[7:0]);
               repeat ((seglen > 14) ? 12 : int'(seglen) - 2)
                  img.push_back(8'($urandom_range(0, 255)));
            end
         end
         // sos header then entropy data with frequent ff
         if ($urandom_range(0, 3) != 0) begin
            seglen = 16'($urandom_range(2, 6));
            img.push_back(MARK_FF);
            img.push_back(MARK_SOS);
            img.push_back(seglen[15:8]);
            img.push_back(seglen[7:0]);
            repeat (int'(seglen) - 2) img.push_back(8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 16))
               img.push_back(($urandom_range(0, 3) == 0) ? MARK_FF
                                                         : 8'($urandom_range(0, 255)));
         end
         img.push_back(MARK_FF);
         img.push_back(MARK_EOI);
         if ($urandom_range(0, 4) == 0)
            img[$urandom_range(0, img.size() - 1)] = 8'($urandom_range(0, 255));
      end
      cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, img.size()) : img.size();
      end_flag = (cut < img.size()) ? ($urandom_range(0, 1) == 1)
                                     : ($urandom_range(0, 6) == 0);
      for (int i = 0; i < cut; i++)
         push_byte(img[i], i == 0, end_flag && i == cut - 1);
      queued_count += cut;
      // stray bytes after the candidate
      if ($urandom_range(0, 5) == 0) begin
         repeat ($urandom_range(1, 3))
            push_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic run_phase(input logic [31:0] limit, input int idle, input int stall,
                            input int hold, input int target);
      write_max_bytes(limit);
      idle_pct = idle;
      stall_pct = stall;
      hold_cycles = hold;
      queued_count = 0;
      while (queued_count < target) add_candidate();
      drain();
   endtask

   // main sequence
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: ignored byte, not jpeg cases, eoi with last, unknown marker,
      // non-ff where a marker belongs, sos of length two with ff ff d9, length below two
      push_byte(8'h00, 1'b0, 1'b0);
      push_byte(8'h12, 1'b1, 1'b0);
      push_byte(MARK_FF, 1'b1, 1'b1);
      push_byte(MARK_FF, 1'b1, 1'b0); push_byte(8'h00, 1'b0, 1'b0);
      push_byte(MARK_FF, 1'b1, 1'b0); push_byte(MARK_SOI, 1'b0, 1'b0);
      push_byte(MARK_FF, 1'b0, 1'b0); push_byte(MARK_EOI, 1'b0, 1'b1);
      push_byte(MARK_FF, 1'b1, 1'b0); push_byte(MARK_SOI, 1'b0, 1'b0);
      push_byte(MARK_FF, 1'b0, 1'b0); push_byte(MARK_FF, 1'b0, 1'b0);
      push_byte(MARK_FF, 1'b1, 1'b0); push_byte(MARK_SOI, 1'b0, 1'b0);
      push_byte(8'h00, 1'b0, 1'b0);
      push_byte(MARK_FF, 1'b1, 1'b0); push_byte(MARK_SOI, 1'b0, 1'b0);
      push_byte(MARK_FF, 1'b0, 1'b0); push_byte(MARK_SOS, 1'b0, 1'b0);
      push_byte(8'h00, 1'b0, 1'b0); push_byte(8'h02, 1'b0, 1'b0);
      push_byte(MARK_FF, 1'b0, 1'b0); push_byte(MARK_FF, 1'b0, 1'b0);
      push_byte(MARK_EOI, 1'b0, 1'b0);
      push_byte(MARK_FF, 1'b1, 1'b0); push_byte(MARK_SOI, 1'b0, 1'b0);
      push_byte(MARK_FF, 1'b0, 1'b0); push_byte(8'hE0, 1'b0, 1'b0);
      push_byte(8'h00, 1'b0, 1'b0); push_byte(8'h01, 1'b0, 1'b0);
      drain();

      // random phases across limits and flow control
      run_phase(32'h03FF_FFFF, 0, 0, 0, 400);
      run_phase(32'd1, 71, 0, 0, 60);
      run_phase(32'd40, 0, 71, 0, 400);
      run_phase(32'd0, 8, 8, 0, 40);
      run_phase(32'(MAX_BYTES_RESET), 8, 8, 0, 400);
      // long receiver hold-off while bytes keep coming, so the input backs up
      run_phase(32'd25, 0, 0, 300, 250);
      run_phase(32'd200, 8, 8, 0, 250);

      repeat (10) @(posedge clock);
      if (expected_lengths.size() != 0)
         flag_error($sformatf("%0d results never arrived", expected_lengths.size()));
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/jlf_pkg.sv
hw/rtl/jlf_csr.sv
hw/rtl/jlf_front.sv
hw/rtl/jlf_queue.sv
hw/rtl/jlf_parser.sv
hw/rtl/jpeg_length_finder.sv
hw/rtl/jlf_checker.sv
verif/testbench.sv
